@@ rtl/ups_pkg.sv @@
// Shared constants, types and helper functions for the unicycle pose step pipeline.
package ups_pkg;

    // Number of CORDIC rotation cells (8 to 30)
    localparam int CORDIC_STAGES = 16;

    localparam int DATA_W  = 32;              // Q16.16 signals
    localparam int T_W     = 24;              // Q8.16 sample interval
    localparam int IN_W    = 5 * DATA_W;      // slave tdata width
    localparam int OUT_W   = 3 * DATA_W;      // master tdata width
    localparam int PROD_W  = DATA_W + T_W + 1;
    localparam int M_W     = 41;              // interval * velocity, Q16.16
    localparam int XY_W    = 34;              // CORDIC x/y, Q2.30 with headroom
    localparam int Z_W     = 34;              // CORDIC angle, Q2.30 with headroom
    localparam int SHAMT_W = 5;
    localparam int QUO_W   = 14;              // quotient of heading / (2*pi)
    localparam int RED_W   = 20;              // reduced angle, Q4.16
    localparam int HI_W    = (M_W - 15) + XY_W;
    localparam int LO_W    = 16 + XY_W;
    localparam int SUM_W   = HI_W + 16;
    localparam int D_W     = SUM_W - 30;

    // Pipeline bookkeeping
    localparam int PIPE_DEPTH = CORDIC_STAGES + 10;
    localparam int SIDE_DEPTH = CORDIC_STAGES + 4;

    localparam logic [T_W-1:0] SAMPLE_INTERVAL_RST = 24'd6554;

    // Angle reduction constants
    localparam logic [DATA_W-1:0] TWO_PI_Q16  = 32'd411775;
    localparam logic [63:0]       RECIP_RAW   = (64'd1 << 50) / 64'd411775;
    localparam logic [DATA_W-1:0] TWO_PI_RECIP = RECIP_RAW[DATA_W-1:0];
    localparam logic [63:0]       OFS_RAW     = (64'd1 << 31) % 64'd411775;
    localparam logic [RED_W-1:0]  TWO_PI_R    = 20'd411775;
    localparam logic [RED_W-1:0]  OFS_R       = OFS_RAW[RED_W-1:0];
    localparam logic [RED_W-1:0]  M_MINUS_OFS = TWO_PI_R - OFS_R;

    localparam logic signed [RED_W-1:0] TWO_PI_S  = 20'sd411775;
    localparam logic signed [RED_W-1:0] PI_S      = 20'sd205887;
    localparam logic signed [RED_W-1:0] HALF_PI_S = 20'sd102944;

    localparam logic signed [XY_W-1:0] CORDIC_GAIN = 34'sd652032874;

    typedef struct packed {
        logic signed [XY_W-1:0] x;
        logic signed [XY_W-1:0] y;
        logic signed [Z_W-1:0]  z;
        logic                   neg;
    } cordic_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] x_pos;
        logic signed [DATA_W-1:0] y_pos;
        logic signed [M_W-1:0]    travel;
        logic signed [DATA_W-1:0] heading_next;
    } side_t;

    // atan(2^-k) in Q2.30, rounded to nearest
    function automatic logic signed [Z_W-1:0] atan_q30(input int k);
        logic signed [Z_W-1:0] a;
        case (k)
            0:  a = 34'sd843314857;
            1:  a = 34'sd497837829;
            2:  a = 34'sd263043837;
            3:  a = 34'sd133525159;
            4:  a = 34'sd67021687;
            5:  a = 34'sd33543516;
            6:  a = 34'sd16775851;
            7:  a = 34'sd8388437;
            8:  a = 34'sd4194283;
            9:  a = 34'sd2097149;
            10: a = 34'sd1048576;
            11: a = 34'sd524288;
            12: a = 34'sd262144;
            13: a = 34'sd131072;
            14: a = 34'sd65536;
            15: a = 34'sd32768;
            16: a = 34'sd16384;
            17: a = 34'sd8192;
            18: a = 34'sd4096;
            19: a = 34'sd2048;
            20: a = 34'sd1024;
            21: a = 34'sd512;
            22: a = 34'sd256;
            23: a = 34'sd128;
            24: a = 34'sd64;
            25: a = 34'sd32;
            26: a = 34'sd16;
            27: a = 34'sd8;
            28: a = 34'sd4;
            29: a = 34'sd2;
            default: a = '0;
        endcase
        return a;
    endfunction

    // Clamp to the signed 32-bit range
    function automatic logic signed [DATA_W-1:0] sat32(input logic signed [63:0] v);
        logic signed [DATA_W-1:0] r;
        if (v > 64'sd2147483647)
        begin
            r = 32'sh7FFF_FFFF;
        end
        else if (v < -64'sd2147483648)
        begin
            r = 32'sh8000_0000;
        end
        else
        begin
            r = v[DATA_W-1:0];
        end
        return r;
    endfunction

endpackage

@@ rtl/ups_reduce.sv @@
// Heading reduction modulo 2*pi and quadrant fold, five pipeline stages.
module ups_reduce (
    input  logic                                clk,
    input  logic                                en,
    input  logic signed [ups_pkg::DATA_W-1:0]   heading,
    output ups_pkg::cordic_t                    cord
);

    // Stage a: offset to unsigned, estimate quotient by reciprocal
    logic [ups_pkg::DATA_W-1:0] hu_next;
    logic [63:0]                prod;
    logic [ups_pkg::DATA_W-1:0] hu_a_reg;
    logic [ups_pkg::QUO_W-1:0]  q_reg;

    assign hu_next = {~heading[ups_pkg::DATA_W-1], heading[ups_pkg::DATA_W-2:0]};
    assign prod    = 64'(hu_next) * 64'(ups_pkg::TWO_PI_RECIP);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            hu_a_reg <= hu_next;
            q_reg    <= prod[63:64-ups_pkg::QUO_W];
        end
    end

    // Stage b: remainder estimate, in [0, 4*pi)
    logic [ups_pkg::DATA_W-1:0] qm;
    logic [ups_pkg::DATA_W-1:0] diff;
    logic [ups_pkg::RED_W-1:0]  r1_reg;

    assign qm   = ups_pkg::DATA_W'(q_reg) * ups_pkg::TWO_PI_Q16;
    assign diff = hu_a_reg - qm;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            r1_reg <= diff[ups_pkg::RED_W-1:0];
        end
    end

    // Stage c: one correction step into [0, 2*pi)
    logic [ups_pkg::RED_W-1:0] r2_next;
    logic [ups_pkg::RED_W-1:0] r2_reg;

    assign r2_next = (r1_reg >= ups_pkg::TWO_PI_R) ? r1_reg - ups_pkg::TWO_PI_R : r1_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            r2_reg <= r2_next;
        end
    end

    // Stage d: remove the 2^31 offset, modulo 2*pi
    logic [ups_pkg::RED_W-1:0] r3_next;
    logic [ups_pkg::RED_W-1:0] r3_reg;

    assign r3_next = (r2_reg >= ups_pkg::OFS_R) ? r2_reg - ups_pkg::OFS_R
                                                : r2_reg + ups_pkg::M_MINUS_OFS;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            r3_reg <= r3_next;
        end
    end

    // Stage e: fold into [-pi/2, pi/2], flag the sign flip
    logic signed [ups_pkg::RED_W-1:0] rs;
    logic signed [ups_pkg::RED_W-1:0] rw;
    logic signed [ups_pkg::RED_W-1:0] rf;
    logic                             neg;
    ups_pkg::cordic_t                 cord_next;
    ups_pkg::cordic_t                 cord_reg;

    always_comb
    begin
        rs  = $signed(r3_reg);
        rw  = (rs > ups_pkg::PI_S) ? rs - ups_pkg::TWO_PI_S : rs;
        rf  = rw;
        neg = 1'b0;
        if (rw > ups_pkg::HALF_PI_S)
        begin
            rf  = rw - ups_pkg::PI_S;
            neg = 1'b1;
        end
        else if (rw < -ups_pkg::HALF_PI_S)
        begin
            rf  = rw + ups_pkg::PI_S;
            neg = 1'b1;
        end
        cord_next.x   = ups_pkg::CORDIC_GAIN;
        cord_next.y   = '0;
        cord_next.z   = {{(ups_pkg::Z_W-ups_pkg::RED_W){rf[ups_pkg::RED_W-1]}}, rf} << 14;
        cord_next.neg = neg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            cord_reg <= cord_next;
        end
    end

    assign cord = cord_reg;

endmodule

@@ rtl/ups_cordic_cell.sv @@
// One rotation-mode CORDIC cell: a single micro-rotation and its output register.
module ups_cordic_cell (
    input  logic                              clk,
    input  logic                              en,
    input  logic [ups_pkg::SHAMT_W-1:0]       shamt,
    input  logic signed [ups_pkg::Z_W-1:0]    atan,
    input  ups_pkg::cordic_t                  cin,
    output ups_pkg::cordic_t                  cout
);

    logic signed [ups_pkg::XY_W-1:0] xi;
    logic signed [ups_pkg::XY_W-1:0] yi;
    logic signed [ups_pkg::Z_W-1:0]  zi;
    logic signed [ups_pkg::XY_W-1:0] xs;
    logic signed [ups_pkg::XY_W-1:0] ys;
    ups_pkg::cordic_t                cell_next;
    ups_pkg::cordic_t                cell_reg;

    assign xi = cin.x;
    assign yi = cin.y;
    assign zi = cin.z;
    assign xs = xi >>> shamt;
    assign ys = yi >>> shamt;

    // Rotate toward zero residual angle; both updates use the old x and y
    always_comb
    begin
        cell_next.neg = cin.neg;
        if (!zi[ups_pkg::Z_W-1])
        begin
            cell_next.x = xi - ys;
            cell_next.y = yi + xs;
            cell_next.z = zi - atan;
        end
        else
        begin
            cell_next.x = xi + ys;
            cell_next.y = yi - xs;
            cell_next.z = zi + atan;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            cell_reg <= cell_next;
        end
    end

    assign cout = cell_reg;

endmodule

@@ rtl/ups_scale.sv @@
// Displacement scaling by cos/sin, rounding and saturated position sums, four stages.
module ups_scale (
    input  logic                               clk,
    input  logic                               en,
    input  ups_pkg::cordic_t                   cord,
    input  ups_pkg::side_t                     side,
    output logic [ups_pkg::DATA_W-1:0]         x_next,
    output logic [ups_pkg::DATA_W-1:0]         y_next,
    output logic [ups_pkg::DATA_W-1:0]         heading_next
);

    localparam int A_W = ups_pkg::M_W - 15;

    // Stage 1: apply the quadrant sign flip
    logic signed [ups_pkg::XY_W-1:0] cx;
    logic signed [ups_pkg::XY_W-1:0] sy;
    logic signed [ups_pkg::XY_W-1:0] cos1_reg;
    logic signed [ups_pkg::XY_W-1:0] sin1_reg;
    ups_pkg::side_t                  side1_reg;

    assign cx = cord.x;
    assign sy = cord.y;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            cos1_reg  <= cord.neg ? -cx : cx;
            sin1_reg  <= cord.neg ? -sy : sy;
            side1_reg <= side;
        end
    end

    // Stage 2: split distance into high and low parts, form partial products
    logic signed [A_W-1:0]           dist_hi;
    logic signed [15:0]              dist_lo;
    logic signed [ups_pkg::HI_W-1:0] hc_next;
    logic signed [ups_pkg::HI_W-1:0] hs_next;
    logic signed [ups_pkg::LO_W-1:0] lc_next;
    logic signed [ups_pkg::LO_W-1:0] ls_next;
    logic signed [ups_pkg::HI_W-1:0] hc_reg;
    logic signed [ups_pkg::HI_W-1:0] hs_reg;
    logic signed [ups_pkg::LO_W-1:0] lc_reg;
    logic signed [ups_pkg::LO_W-1:0] ls_reg;
    ups_pkg::side_t                  side2_reg;

    assign dist_hi = $signed(side1_reg.travel[ups_pkg::M_W-1:15]);
    assign dist_lo = $signed({1'b0, side1_reg.travel[14:0]});
    assign hc_next = dist_hi * cos1_reg;
    assign hs_next = dist_hi * sin1_reg;
    assign lc_next = dist_lo * cos1_reg;
    assign ls_next = dist_lo * sin1_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            hc_reg    <= hc_next;
            hs_reg    <= hs_next;
            lc_reg    <= lc_next;
            ls_reg    <= ls_next;
            side2_reg <= side1_reg;
        end
    end

    // Stage 3: recombine, round to nearest and drop the Q2.30 fraction
    logic [ups_pkg::SUM_W-1:0] sum_c;
    logic [ups_pkg::SUM_W-1:0] sum_s;
    logic [ups_pkg::D_W-1:0]   dx_reg;
    logic [ups_pkg::D_W-1:0]   dy_reg;
    ups_pkg::side_t            side3_reg;

    assign sum_c = ({{(ups_pkg::SUM_W-ups_pkg::HI_W){hc_reg[ups_pkg::HI_W-1]}}, hc_reg} << 15)
                 + {{(ups_pkg::SUM_W-ups_pkg::LO_W){lc_reg[ups_pkg::LO_W-1]}}, lc_reg}
                 + (ups_pkg::SUM_W'(1) << 29);
    assign sum_s = ({{(ups_pkg::SUM_W-ups_pkg::HI_W){hs_reg[ups_pkg::HI_W-1]}}, hs_reg} << 15)
                 + {{(ups_pkg::SUM_W-ups_pkg::LO_W){ls_reg[ups_pkg::LO_W-1]}}, ls_reg}
                 + (ups_pkg::SUM_W'(1) << 29);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dx_reg    <= sum_c[ups_pkg::SUM_W-1:30];
            dy_reg    <= sum_s[ups_pkg::SUM_W-1:30];
            side3_reg <= side2_reg;
        end
    end

    // Stage 4: add to the current position and saturate
    logic [63:0]                xsum;
    logic [63:0]                ysum;
    logic [ups_pkg::DATA_W-1:0] x_next_reg;
    logic [ups_pkg::DATA_W-1:0] y_next_reg;
    logic [ups_pkg::DATA_W-1:0] hn_reg;

    assign xsum = {{32{side3_reg.x_pos[ups_pkg::DATA_W-1]}}, side3_reg.x_pos}
                + {{(64-ups_pkg::D_W){dx_reg[ups_pkg::D_W-1]}}, dx_reg};
    assign ysum = {{32{side3_reg.y_pos[ups_pkg::DATA_W-1]}}, side3_reg.y_pos}
                + {{(64-ups_pkg::D_W){dy_reg[ups_pkg::D_W-1]}}, dy_reg};

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x_next_reg <= ups_pkg::sat32($signed(xsum));
            y_next_reg <= ups_pkg::sat32($signed(ysum));
            hn_reg     <= side3_reg.heading_next;
        end
    end

    assign x_next       = x_next_reg;
    assign y_next       = y_next_reg;
    assign heading_next = hn_reg;

endmodule

@@ rtl/unicycle_pose_step.sv @@
// Top level: forward-Euler unicycle pose step, fully pipelined stream block.
// Depth: CORDIC_STAGES + 10 stages; m_tvalid is the valid flag of the last stage.
// Throughput: one pose per cycle while not stalled; every stage advances together on one
// enable, which is set whenever the output register is empty or being taken.
// Reset: rst_n clears all valid flags and loads sample_interval with 6554 (0.1 s);
// the payload registers are not reset.
module unicycle_pose_step (
    input  logic                          clk,
    input  logic                          rst_n,
    // Input pose and control
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // s_tdata fields, low bit up: x_pos, y_pos, heading, lin_vel, ang_vel (32 bits each)
    input  logic [ups_pkg::IN_W-1:0]      s_tdata,
    // Next pose
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // m_tdata fields, low bit up: x_next, y_next, heading_next (32 bits each)
    output logic [ups_pkg::OUT_W-1:0]     m_tdata,
    // sample_interval register, unsigned Q8.16 seconds
    input  logic                          cfg_we,
    input  logic [ups_pkg::T_W-1:0]       cfg_wdata
);

    localparam int N  = ups_pkg::CORDIC_STAGES;
    localparam int DW = ups_pkg::DATA_W;

    // Sample interval register
    logic [ups_pkg::T_W-1:0] interval_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            interval_reg <= ups_pkg::SAMPLE_INTERVAL_RST;
        end
        else if (cfg_we)
        begin
            interval_reg <= cfg_wdata;
        end
    end

    // Global advance: move every stage when the output slot is free or drained
    logic en;
    logic [ups_pkg::PIPE_DEPTH-1:0] vld_reg;
    logic [ups_pkg::PIPE_DEPTH-1:0] vld_next;

    assign en       = m_tready || !vld_reg[ups_pkg::PIPE_DEPTH-1];
    assign s_tready = en;
    assign vld_next = {vld_reg[ups_pkg::PIPE_DEPTH-2:0], s_tvalid};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= vld_next;
        end
    end

    // Stage 1: capture the transaction
    logic signed [DW-1:0] x1_reg;
    logic signed [DW-1:0] y1_reg;
    logic signed [DW-1:0] h1_reg;
    logic signed [DW-1:0] v1_reg;
    logic signed [DW-1:0] w1_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x1_reg <= s_tdata[DW-1:0];
            y1_reg <= s_tdata[2*DW-1:DW];
            h1_reg <= s_tdata[3*DW-1:2*DW];
            v1_reg <= s_tdata[4*DW-1:3*DW];
            w1_reg <= s_tdata[5*DW-1:4*DW];
        end
    end

    // Stage 2: scale both velocities by the interval
    logic signed [ups_pkg::T_W:0]      t_s;
    logic signed [ups_pkg::PROD_W-1:0] vt_next;
    logic signed [ups_pkg::PROD_W-1:0] wt_next;
    logic signed [ups_pkg::PROD_W-1:0] vt2_reg;
    logic signed [ups_pkg::PROD_W-1:0] wt2_reg;
    logic signed [DW-1:0]              x2_reg;
    logic signed [DW-1:0]              y2_reg;
    logic signed [DW-1:0]              h2_reg;

    assign t_s     = $signed({1'b0, interval_reg});
    assign vt_next = v1_reg * t_s;
    assign wt_next = w1_reg * t_s;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            vt2_reg <= vt_next;
            wt2_reg <= wt_next;
            x2_reg  <= x1_reg;
            y2_reg  <= y1_reg;
            h2_reg  <= h1_reg;
        end
    end

    // Stage 3: round the products back to Q16.16 and finish the heading
    logic [ups_pkg::PROD_W-1:0] vt_rnd;
    logic [ups_pkg::PROD_W-1:0] wt_rnd;
    logic [ups_pkg::M_W-1:0]    dh;
    logic [63:0]                hsum;
    ups_pkg::side_t             side_next;

    assign vt_rnd = vt2_reg + ups_pkg::PROD_W'(32768);
    assign wt_rnd = wt2_reg + ups_pkg::PROD_W'(32768);
    assign dh     = wt_rnd[ups_pkg::PROD_W-1:16];
    assign hsum   = {{32{h2_reg[DW-1]}}, h2_reg}
                  + {{(64-ups_pkg::M_W){dh[ups_pkg::M_W-1]}}, dh};

    always_comb
    begin
        side_next.x_pos        = x2_reg;
        side_next.y_pos        = y2_reg;
        side_next.travel       = vt_rnd[ups_pkg::PROD_W-1:16];
        side_next.heading_next = ups_pkg::sat32($signed(hsum));
    end

    // Hold the position, distance and finished heading beside the angle path
    ups_pkg::side_t side_pipe_reg [ups_pkg::SIDE_DEPTH];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            side_pipe_reg[0] <= side_next;
            for (int k = 1; k < ups_pkg::SIDE_DEPTH; k++)
            begin
                side_pipe_reg[k] <= side_pipe_reg[k-1];
            end
        end
    end

    // Angle path: reduction (stages 2 to 6), then one CORDIC cell per stage
    ups_pkg::cordic_t cord [N+1];

    ups_reduce u_reduce (
        .clk     (clk),
        .en      (en),
        .heading (h1_reg),
        .cord    (cord[0])
    );

    for (genvar g = 0; g < N; g++)
    begin : g_cell
        ups_cordic_cell u_cell (
            .clk   (clk),
            .en    (en),
            .shamt (ups_pkg::SHAMT_W'(g)),
            .atan  (ups_pkg::atan_q30(g)),
            .cin   (cord[g]),
            .cout  (cord[g+1])
        );
    end

    // Scale, round and saturate; the last stage is the output register
    logic [DW-1:0] x_next;
    logic [DW-1:0] y_next;
    logic [DW-1:0] heading_next;

    ups_scale u_scale (
        .clk          (clk),
        .en           (en),
        .cord         (cord[N]),
        .side         (side_pipe_reg[ups_pkg::SIDE_DEPTH-1]),
        .x_next       (x_next),
        .y_next       (y_next),
        .heading_next (heading_next)
    );

    assign m_tvalid = vld_reg[ups_pkg::PIPE_DEPTH-1];
    assign m_tdata  = {heading_next, y_next, x_next};

endmodule
